// ===== design/assert_macros.svh =====
// Assertion macros used by the terminal buffer engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTB_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttb: next-cycle check failed");

`endif

// ===== design/ttb_pkg.sv =====
`timescale 1ns / 1ps

package ttb_pkg;

    // Field widths of the item ports
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_MOVE    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_REFRESH = 2'd3
    } op_t;

    // Special bytes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    typedef struct packed {
        op_t               opcode;
        logic [CHAR_W-1:0] char_in;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  last_row;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] cell_char;
        logic              cell_changed;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
    } res_t;

endpackage

// ===== design/text_terminal_buffer.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_ready  opcode, char_in, row, col, last_row
// out      source     out_valid/out_ready  cell_char, cell_changed, cursor_col,
//                                          cursor_row, scrolled
//
// Write, move and out-of-range refresh finish in S_EXEC; an in-range refresh adds a compare step.
// Clear walks the cleared rows, and a scrolling write walks the rows it moves,
// one cell a cycle through the row walker.
// After reset both buffers are zeroed in a sweep of ROWS * COLUMNS cells
// (2560 at defaults) during which in_ready stays low.
// The output register lets the next item start while a result waits.

module text_terminal_buffer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ttb_pkg::OP_W-1:0]     opcode,
    input  logic [ttb_pkg::CHAR_W-1:0]   char_in,
    input  logic [ttb_pkg::ROW_W-1:0]    row,
    input  logic [ttb_pkg::COL_W-1:0]    col,
    input  logic [ttb_pkg::ROW_W-1:0]    last_row,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ttb_pkg::CHAR_W-1:0]   cell_char,
    output logic                         cell_changed,
    output logic [ttb_pkg::COL_W-1:0]    cursor_col,
    output logic [ttb_pkg::ROW_W-1:0]    cursor_row,
    output logic                         scrolled
);

    import ttb_pkg::*;

    cmd_t cmd;
    res_t res;
    res_t out_reg;
    logic out_valid_reg;
    logic eng_ready;
    logic start;
    logic res_ready;

    // Pack the input transfer
    always_comb
    begin
        cmd.opcode   = op_t'(opcode);
        cmd.char_in  = char_in;
        cmd.row      = row;
        cmd.col      = col;
        cmd.last_row = last_row;
    end

    assign in_ready  = eng_ready;
    assign start     = in_valid && eng_ready;
    assign res_ready = !out_valid_reg || out_ready;

    ttb_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .ready     (eng_ready),
        .res       (res),
        .res_ready (res_ready)
    );

    // Hold the result until the output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_char    = out_reg.cell_char;
    assign cell_changed = out_reg.cell_changed;
    assign cursor_col   = out_reg.cursor_col;
    assign cursor_row   = out_reg.cursor_row;
    assign scrolled     = out_reg.scrolled;

endmodule

// ===== design/ttb_ram.sv =====
`timescale 1ns / 1ps

module ttb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2560
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry and register one read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ttb_engine.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttb_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ttb_pkg::cmd_t cmd,
    output logic          ready,
    output ttb_pkg::res_t res,
    input  logic          res_ready
);

    import ttb_pkg::*;

    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int AW        = $clog2(CELLS);
    localparam int FIRST_ROW = ROWS / 2 + 1;

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_CLEAR  = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_FLUSH  = 8'b0010_0000,
        S_REFR   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [CW-1:0]     x_reg, x_next;
    logic [RW-1:0]     y_reg, y_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     col_cnt_reg, col_cnt_next;
    logic [RW-1:0]     row_cnt_reg, row_cnt_next;
    logic [RW-1:0]     end_row_reg, end_row_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic              pend_blank_reg, pend_blank_next;
    logic [CHAR_W-1:0] res_char_reg, res_char_next;
    logic              res_changed_reg, res_changed_next;
    logic              res_scrolled_reg, res_scrolled_next;

    // Shared row * COLUMNS + col address unit
    logic [RW-1:0]     mul_row;
    logic [CW-1:0]     mul_col;
    logic [AW-1:0]     mul_addr;

    // Memory ports
    logic              cur_we, cur_re, shw_we, shw_re;
    logic [AW-1:0]     cur_waddr, cur_raddr, shw_waddr;
    logic [CHAR_W-1:0] cur_wdata, shw_wdata, cur_rdata, shw_rdata;

    // Write decode
    logic              wr_nl, wr_bs, x_is0, y_up, scroll_hit;
    logic [CW:0]       x_inc;
    logic [CW-1:0]     x_w;
    logic [RW-1:0]     last_sat;

    // Walk counter
    logic              col_wrap, walk_last;

    assign mul_addr = AW'(32'(mul_row) * COLUMNS + 32'(mul_col));

    assign wr_nl      = cmd_reg.char_in inside {CH_LF, CH_CR};
    assign wr_bs      = cmd_reg.char_in == CH_BS;
    assign x_is0      = x_reg == '0;
    assign x_inc      = {1'b0, x_reg} + (CW+1)'(1);
    assign x_w        = wr_bs ? (x_reg - CW'(1)) : x_reg;
    assign y_up       = wr_nl || (!wr_bs && (32'(x_inc) == COLUMNS));
    assign scroll_hit = y_up && (y_reg == RW'(ROWS - 1));
    assign last_sat   = (32'(cmd_reg.last_row) > ROWS - 1) ? RW'(ROWS - 1)
                                                          : RW'(cmd_reg.last_row);

    assign col_wrap  = col_cnt_reg == CW'(COLUMNS - 1);
    assign walk_last = col_wrap && (row_cnt_reg == end_row_reg);

    assign ready = (state_reg == S_IDLE) || ((state_reg == S_DONE) && res_ready);

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        ptr_next          = ptr_reg;
        col_cnt_next      = col_cnt_reg;
        row_cnt_next      = row_cnt_reg;
        end_row_next      = end_row_reg;
        pend_valid_next   = 1'b0;
        pend_addr_next    = ptr_reg;
        pend_blank_next   = row_cnt_reg == RW'(ROWS - 1);
        res_char_next     = res_char_reg;
        res_changed_next  = res_changed_reg;
        res_scrolled_next = res_scrolled_reg;

        mul_row   = y_reg;
        mul_col   = x_w;

        cur_we    = 1'b0;
        cur_waddr = ptr_reg;
        cur_wdata = '0;
        cur_re    = 1'b0;
        cur_raddr = AW'(32'(ptr_reg) + COLUMNS);
        shw_we    = 1'b0;
        shw_waddr = ptr_reg;
        shw_wdata = '0;
        shw_re    = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                // Zero both buffers, one cell a cycle
                cur_we       = 1'b1;
                shw_we       = 1'b1;
                ptr_next     = ptr_reg + AW'(1);
                col_cnt_next = col_wrap ? '0 : col_cnt_reg + CW'(1);
                row_cnt_next = col_wrap ? row_cnt_reg + RW'(1) : row_cnt_reg;
                if (walk_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_char_next     = '0;
                res_changed_next  = 1'b0;
                res_scrolled_next = 1'b0;
                state_next        = S_DONE;
                case (cmd_reg.opcode)
                    OP_WRITE:
                    begin
                        // Store at the cursor and advance it; a newline only moves it, a backspace blanks leftward
                        cur_we    = !wr_nl && !(wr_bs && x_is0);
                        cur_waddr = mul_addr;
                        cur_wdata = wr_bs ? CH_BLANK : cmd_reg.char_in;
                        if (wr_nl)
                        begin
                            x_next = '0;
                        end
                        else if (wr_bs)
                        begin
                            // Hold the cursor at the left edge
                            x_next = x_is0 ? x_reg : x_w;
                        end
                        else if (32'(x_inc) == COLUMNS)
                        begin
                            x_next = '0;
                        end
                        else
                        begin
                            x_next = x_inc[CW-1:0];
                        end
                        if (scroll_hit)
                        begin
                            y_next            = RW'(ROWS - 1);
                            res_scrolled_next = 1'b1;
                            ptr_next          = AW'(FIRST_ROW * COLUMNS);
                            row_cnt_next      = RW'(FIRST_ROW);
                            col_cnt_next      = '0;
                            end_row_next      = RW'(ROWS - 1);
                            state_next        = S_SCROLL;
                        end
                        else if (y_up)
                        begin
                            y_next = y_reg + RW'(1);
                        end
                    end

                    OP_MOVE:
                    begin
                        // Saturate the target to the screen
                        x_next = (32'(cmd_reg.col) > COLUMNS - 1) ? CW'(COLUMNS - 1)
                                                                 : CW'(cmd_reg.col);
                        y_next = (32'(cmd_reg.row) > ROWS - 1) ? RW'(ROWS - 1)
                                                              : RW'(cmd_reg.row);
                    end

                    OP_CLEAR:
                    begin
                        // Home the cursor and start the row walk if the row span is not empty
                        x_next  = '0;
                        y_next  = '0;
                        mul_row = RW'(cmd_reg.row);
                        mul_col = '0;
                        if (32'(cmd_reg.row) <= 32'(last_sat))
                        begin
                            ptr_next     = mul_addr;
                            row_cnt_next = RW'(cmd_reg.row);
                            col_cnt_next = '0;
                            end_row_next = last_sat;
                            state_next   = S_CLEAR;
                        end
                    end

                    OP_REFRESH:
                    begin
                        // Read both copies of an in-range cell
                        mul_row   = RW'(cmd_reg.row);
                        mul_col   = CW'(cmd_reg.col);
                        cur_raddr = mul_addr;
                        if ((32'(cmd_reg.row) < ROWS) && (32'(cmd_reg.col) < COLUMNS))
                        begin
                            cur_re     = 1'b1;
                            shw_re     = 1'b1;
                            ptr_next   = mul_addr;
                            state_next = S_REFR;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CLEAR:
            begin
                // Blank current, zero shown
                cur_we       = 1'b1;
                cur_wdata    = CH_BLANK;
                shw_we       = 1'b1;
                ptr_next     = ptr_reg + AW'(1);
                col_cnt_next = col_wrap ? '0 : col_cnt_reg + CW'(1);
                row_cnt_next = col_wrap ? row_cnt_reg + RW'(1) : row_cnt_reg;
                if (walk_last)
                begin
                    state_next = S_DONE;
                end
            end

            S_SCROLL:
            begin
                // Zero shown, read the row below and write it back in the next cycle
                shw_we          = 1'b1;
                cur_re          = row_cnt_reg != RW'(ROWS - 1);
                pend_valid_next = 1'b1;
                cur_we          = pend_valid_reg;
                cur_waddr       = pend_addr_reg;
                cur_wdata       = pend_blank_reg ? CH_BLANK : cur_rdata;
                ptr_next        = ptr_reg + AW'(1);
                col_cnt_next    = col_wrap ? '0 : col_cnt_reg + CW'(1);
                row_cnt_next    = col_wrap ? row_cnt_reg + RW'(1) : row_cnt_reg;
                if (walk_last)
                begin
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                // Drain the last pending write
                cur_we     = 1'b1;
                cur_waddr  = pend_addr_reg;
                cur_wdata  = pend_blank_reg ? CH_BLANK : cur_rdata;
                state_next = S_DONE;
            end

            S_REFR:
            begin
                // Compare, then sync the shown copy
                res_char_next    = cur_rdata;
                res_changed_next = cur_rdata != shw_rdata;
                shw_we           = 1'b1;
                shw_wdata        = cur_rdata;
                state_next       = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = start ? S_EXEC : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            x_reg          <= '0;
            y_reg          <= '0;
            ptr_reg        <= '0;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            end_row_reg    <= RW'(ROWS - 1);
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            ptr_reg        <= ptr_next;
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            end_row_reg    <= end_row_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
        pend_addr_reg    <= pend_addr_next;
        pend_blank_reg   <= pend_blank_next;
        res_char_reg     <= res_char_next;
        res_changed_reg  <= res_changed_next;
        res_scrolled_reg <= res_scrolled_next;
    end

    ttb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .re    (cur_re),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    ttb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_shw_ram (
        .clk   (clk),
        .we    (shw_we),
        .waddr (shw_waddr),
        .wdata (shw_wdata),
        .re    (shw_re),
        .raddr (cur_raddr),
        .rdata (shw_rdata)
    );

    // Result
    always_comb
    begin
        res.valid        = state_reg == S_DONE;
        res.cell_char    = res_char_reg;
        res.cell_changed = res_changed_reg;
        res.cursor_col   = COL_W'(x_reg);
        res.cursor_row   = ROW_W'(y_reg);
        res.scrolled     = res_scrolled_reg;
    end

    `TTB_ASSERT(a_cursor_on_screen, clk, rst_n, 1'b1,
        (32'(x_reg) < COLUMNS) && (32'(y_reg) < ROWS))
    `TTB_ASSERT(a_walk_addr_tracks, clk, rst_n,
        (state_reg == S_INIT) || (state_reg == S_CLEAR) || (state_reg == S_SCROLL),
        32'(ptr_reg) == 32'(row_cnt_reg) * COLUMNS + 32'(col_cnt_reg))
    `TTB_ASSERT(a_cur_no_rw_overlap, clk, rst_n, cur_we && cur_re,
        cur_waddr != cur_raddr)
    `TTB_ASSERT(a_scroll_parks_cursor, clk, rst_n, res.valid && res.scrolled,
        (res.cursor_col == '0) && (res.cursor_row == ROW_W'(ROWS - 1)))
    `TTB_ASSERT_NEXT(a_scroll_leads_flush, clk, rst_n,
        (state_reg == S_SCROLL) && walk_last, state_reg == S_FLUSH)

endmodule
